FILE: rtl/fsa_pkg.sv
// Package for the slot allocator: payload structs, command and status codes,
// register map and sizing constants. No dependencies.
`default_nettype none

package fsa_pkg;

   localparam int SLOT_W        = 12;
   localparam int CHUNK_W       = 4;
   localparam int OFFSET_W      = 24;
   localparam int STATUS_W      = 2;
   localparam int CMD_W         = 2;
   localparam int OBJ_SIZE_W    = 17;
   localparam int ALIGN_W       = 13;
   localparam int SPC_W         = 9;
   localparam int ASIZE_W       = OBJ_SIZE_W + 1;
   localparam int REM_W         = 8;
   localparam int PROD_W        = REM_W + ASIZE_W;

   localparam int MAX_CHUNKS          = 16;
   localparam int MAX_SLOTS_PER_CHUNK = 256;
   localparam int CHUNKS_W            = $clog2(MAX_CHUNKS + 1);
   localparam int QDEPTH              = 4096;
   localparam int QADDR_W             = $clog2(QDEPTH);
   localparam int QCOUNT_W            = QADDR_W + 1;
   localparam int DIV_STEPS           = SLOT_W;
   localparam int DIV_CNT_W           = $clog2(DIV_STEPS);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_OBJECT_SIZE     = 2'd0;
   localparam logic [1:0] REG_ALIGNMENT       = 2'd1;
   localparam logic [1:0] REG_SLOTS_PER_CHUNK = 2'd2;

   localparam logic [OBJ_SIZE_W-1:0] OBJECT_SIZE_RESET     = OBJ_SIZE_W'(256);
   localparam logic [ALIGN_W-1:0]    ALIGNMENT_RESET       = ALIGN_W'(256);
   localparam logic [SPC_W-1:0]      SLOTS_PER_CHUNK_RESET = SPC_W'(64);

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL   = 2'd2;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SLOT_W-1:0] slot;
   } fsa_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_out;
      logic [CHUNK_W-1:0]  chunk;
      logic [OFFSET_W-1:0] byte_offset;
      logic [STATUS_W-1:0] status;
   } fsa_rsp_type;

   typedef struct packed {
      logic              start;
      logic [SLOT_W-1:0] dividend;
      logic [SPC_W-1:0]  divisor;
   } fsa_div_req_type;

   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] quot;
      logic [REM_W-1:0]  rem;
   } fsa_div_rsp_type;

   function automatic logic [SPC_W-1:0] eff_spc(input logic [SPC_W-1:0] spc);
      logic [SPC_W-1:0] s;
      s = spc;
      if (s == '0) s = SPC_W'(1);
      if (s > SPC_W'(MAX_SLOTS_PER_CHUNK)) s = SPC_W'(MAX_SLOTS_PER_CHUNK);
      return s;
   endfunction

   function automatic logic [ASIZE_W-1:0] aligned_size(
      input logic [OBJ_SIZE_W-1:0] size,
      input logic [ALIGN_W-1:0]    align
   );
      logic [ALIGN_W-1:0] mask;
      logic [ASIZE_W-1:0] sum;
      mask = '0;
      for (int i = 0; i < ALIGN_W; i++) begin
         if (align[i]) mask = ALIGN_W'((1 << i) - 1);
      end
      sum = {1'b0, size} + ASIZE_W'(mask);
      if (align == '0) return ASIZE_W'(size);
      return sum & ~ASIZE_W'(mask);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/fsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/fsa_div.sv
// Bit-serial restoring divider: slot index by slots per chunk, one quotient
// bit per cycle. Depends on fsa_pkg.
`default_nettype none

module fsa_div
   import fsa_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire fsa_div_req_type div_req,
   output fsa_div_rsp_type      div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0]    quot_ff, quot_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [SPC_W-1:0]     divisor_ff, divisor_in;
   logic [SPC_W-1:0]     trial;
   logic                 fits;

   assign trial = {rem_ff, quot_ff[SLOT_W-1]};
   assign fits  = trial >= divisor_ff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[SLOT_W-2:0], fits};
         rem_in  = fits ? REM_W'(trial - divisor_ff) : REM_W'(trial);
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/fifo_slot_allocator_unit.sv
// Slot allocator top level: command sequencer, freed-slot queue and registers.
// Depends on fsa_pkg, fsa_ram and fsa_div.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one command: allocate,
//   free or locate a slot. rsp channel (rsp_valid/rsp_stall/rsp_data) returns
//   exactly one transaction per command: slot, chunk, byte offset and status.
//   csr_* is an APB-style port for object_size (0x0), alignment (0x4) and
//   slots_per_chunk (0x8); write only while no command is in flight.
// Sequencing:
//   Allocate and locate wait for the divider (S_DIV), then multiply (S_MUL) and
//   register the result in S_DONE; an allocate from the freed queue first reads
//   the RAM in S_RDQ. Free, undefined and out-of-space allocate commands go
//   straight to S_DONE. The sequencer returns to idle as rsp_valid is registered,
//   so the next command may be accepted while the result waits. One command is in
//   flight at a time; the shared 12-step bit-serial divider splits a slot into
//   chunk and position. req_stall is high while a command is in flight.
// Reset: one chunk open, freed queue empty, registers at their defaults.
// Stall: a result waits in the output register while rsp_stall is high; the
//   next command may be accepted meanwhile and finishes into the register once
//   it frees.
`default_nettype none

module fifo_slot_allocator_unit
   import fsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire fsa_req_type           req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output fsa_rsp_type                rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDQ,
      S_DIV,
      S_MUL,
      S_DONE
   } state_type;

   // configuration
   logic [OBJ_SIZE_W-1:0] object_size_ff;
   logic [ALIGN_W-1:0]    alignment_ff;
   logic [SPC_W-1:0]      spc_ff;
   logic                  csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff <= OBJECT_SIZE_RESET;
         alignment_ff   <= ALIGNMENT_RESET;
         spc_ff         <= SLOTS_PER_CHUNK_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_OBJECT_SIZE:     object_size_ff <= csr_pwdata[OBJ_SIZE_W-1:0];
            REG_ALIGNMENT:       alignment_ff   <= csr_pwdata[ALIGN_W-1:0];
            REG_SLOTS_PER_CHUNK: spc_ff         <= csr_pwdata[SPC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_OBJECT_SIZE:     csr_prdata = CSR_DATA_W'(object_size_ff);
         REG_ALIGNMENT:       csr_prdata = CSR_DATA_W'(alignment_ff);
         REG_SLOTS_PER_CHUNK: csr_prdata = CSR_DATA_W'(spc_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // sequencer state
   state_type             state_ff, state_in;
   logic [CHUNKS_W-1:0]   chunks_open_ff, chunks_open_in;
   logic [SPC_W-1:0]      fresh_next_ff, fresh_next_in;
   logic [QADDR_W-1:0]    queue_head_ff, queue_head_in;
   logic [QADDR_W-1:0]    queue_tail_ff, queue_tail_in;
   logic [QCOUNT_W-1:0]   queue_count_ff, queue_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fsa_rsp_type           rsp_data_ff, rsp_data_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  use_loc_ff, use_loc_in;
   logic [ASIZE_W-1:0]    asize_ff, asize_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   logic [SPC_W-1:0]      spc;
   logic [CHUNK_W-1:0]    chunk_last;
   logic [12:0]           base_fresh;
   logic [12:0]           base_new;
   logic                  accept;

   logic                  q_wr_en;
   logic                  q_rd_en;
   logic [SLOT_W-1:0]     q_rd_data;

   fsa_div_req_type       div_req;
   fsa_div_rsp_type       div_rsp;

   assign spc        = eff_spc(spc_ff);
   assign chunk_last = CHUNK_W'(chunks_open_ff - CHUNKS_W'(1));
   assign base_fresh = 13'(chunk_last) * 13'(spc);
   assign base_new   = 13'(chunks_open_ff[CHUNK_W-1:0]) * 13'(spc);
   assign accept     = req_valid && !req_stall;
   assign req_stall  = state_ff != S_IDLE;

   always_comb begin
      state_in       = state_ff;
      chunks_open_in = chunks_open_ff;
      fresh_next_in  = fresh_next_ff;
      queue_head_in  = queue_head_ff;
      queue_tail_in  = queue_tail_ff;
      queue_count_in = queue_count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      res_slot_in    = res_slot_ff;
      res_status_in  = res_status_ff;
      use_loc_in     = use_loc_ff;
      asize_in       = asize_ff;
      prod_in        = prod_ff;
      q_wr_en        = 1'b0;
      q_rd_en        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = req_data.slot;
      div_req.divisor  = spc;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               asize_in      = aligned_size(object_size_ff, alignment_ff);
               res_slot_in   = req_data.slot;
               res_status_in = ST_OK;
               use_loc_in    = 1'b0;
               state_in      = S_DONE;
               case (req_data.cmd)
                  CMD_ALLOC: begin
                     if (fresh_next_ff < spc) begin
                        res_slot_in      = base_fresh[SLOT_W-1:0] + SLOT_W'(fresh_next_ff);
                        fresh_next_in    = fresh_next_ff + SPC_W'(1);
                        div_req.start    = 1'b1;
                        div_req.dividend = res_slot_in;
                        use_loc_in       = 1'b1;
                        state_in         = S_DIV;
                     end else if (queue_count_ff != '0) begin
                        q_rd_en        = 1'b1;
                        queue_head_in  = queue_head_ff + QADDR_W'(1);
                        queue_count_in = queue_count_ff - QCOUNT_W'(1);
                        use_loc_in     = 1'b1;
                        state_in       = S_RDQ;
                     end else if (chunks_open_ff < CHUNKS_W'(MAX_CHUNKS)) begin
                        res_slot_in      = base_new[SLOT_W-1:0];
                        chunks_open_in   = chunks_open_ff + CHUNKS_W'(1);
                        fresh_next_in    = SPC_W'(1);
                        div_req.start    = 1'b1;
                        div_req.dividend = res_slot_in;
                        use_loc_in       = 1'b1;
                        state_in         = S_DIV;
                     end else begin
                        res_slot_in   = '0;
                        res_status_in = ST_OUT_OF_SPACE;
                     end
                  end
                  CMD_FREE: begin
                     if (queue_count_ff[QCOUNT_W-1]) begin
                        res_status_in = ST_QUEUE_FULL;
                     end else begin
                        q_wr_en        = 1'b1;
                        queue_tail_in  = queue_tail_ff + QADDR_W'(1);
                        queue_count_in = queue_count_ff + QCOUNT_W'(1);
                     end
                  end
                  CMD_LOCATE: begin
                     div_req.start = 1'b1;
                     use_loc_in    = 1'b1;
                     state_in      = S_DIV;
                  end
                  default: ;
               endcase
            end
         end
         S_RDQ: begin
            res_slot_in      = q_rd_data;
            div_req.start    = 1'b1;
            div_req.dividend = q_rd_data;
            state_in         = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(div_rsp.rem) * PROD_W'(asize_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.slot_out  = res_slot_ff;
               rsp_data_in.status    = res_status_ff;
               rsp_data_in.chunk     = '0;
               rsp_data_in.byte_offset = '0;
               if (use_loc_ff) begin
                  rsp_data_in.chunk       = div_rsp.quot[CHUNK_W-1:0];
                  rsp_data_in.byte_offset = (prod_ff[PROD_W-1:OFFSET_W] != '0) ?
                                            OFFSET_MAX : prod_ff[OFFSET_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         chunks_open_ff <= CHUNKS_W'(1);
         fresh_next_ff  <= '0;
         queue_head_ff  <= '0;
         queue_tail_ff  <= '0;
         queue_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         chunks_open_ff <= chunks_open_in;
         fresh_next_ff  <= fresh_next_in;
         queue_head_ff  <= queue_head_in;
         queue_tail_ff  <= queue_tail_in;
         queue_count_ff <= queue_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      use_loc_ff    <= use_loc_in;
      asize_ff      <= asize_in;
      prod_ff       <= prod_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   fsa_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(QDEPTH)
   ) u_queue (
      .clock  (clock),
      .wr_en  (q_wr_en),
      .wr_addr(queue_tail_ff),
      .wr_data(req_data.slot),
      .rd_en  (q_rd_en),
      .rd_addr(queue_head_ff),
      .rd_data(q_rd_data)
   );

   fsa_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count_ff <= QCOUNT_W'(QDEPTH))
      else $error("freed queue count beyond depth");

   a_queue_ptrs: assert property (@(posedge clock) disable iff (reset)
      queue_count_ff[QADDR_W-1:0] == QADDR_W'(queue_tail_ff - queue_head_ff))
      else $error("freed queue pointers disagree with count");

   a_oos: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_data_ff.status == ST_OUT_OF_SPACE |->
         rsp_data_ff.slot_out == '0 && chunks_open_ff == CHUNKS_W'(MAX_CHUNKS))
      else $error("out of space reported with chunks left");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

FILE: tb/slot_outcome_checker.sv
// Checker for the slot allocator: follows register writes, predicts the outcome of
// every accepted command and compares each returned transaction in order.
// Depends on fsa_pkg.
`default_nettype none

module slot_outcome_checker
   import fsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire fsa_req_type           req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire fsa_rsp_type           rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                  csr_pready,
   output int                         fail_count,
   output int                         pending_results
);

   localparam int REPORT_LIMIT = 10;

   logic [OBJ_SIZE_W-1:0] object_size_q;
   logic [ALIGN_W-1:0]    alignment_q;
   logic [SPC_W-1:0]      spc_q;

   logic [CHUNKS_W-1:0]   open_chunks;
   logic [SLOT_W-1:0]     next_fresh;
   logic [SLOT_W-1:0]     freed_slots [QDEPTH];
   logic [QADDR_W-1:0]    free_head;
   logic [QADDR_W-1:0]    free_tail;
   logic [QCOUNT_W-1:0]   free_count;

   fsa_rsp_type           pending_outcomes [$];
   fsa_rsp_type           oldest;
   int                    failures = 0;

   function automatic int chunk_span();
      int s;
      s = int'(spc_q);
      if (s == 0) s = 1;
      if (s > MAX_SLOTS_PER_CHUNK) s = MAX_SLOTS_PER_CHUNK;
      return s;
   endfunction

   function automatic logic [63:0] padded_size();
      logic [63:0] grain;
      grain = 64'd1;
      if (alignment_q == '0) return 64'(object_size_q);
      while ((grain << 1) <= 64'(alignment_q)) grain = grain << 1;
      return (64'(object_size_q) + grain - 64'd1) & ~(grain - 64'd1);
   endfunction

   function automatic fsa_rsp_type place_slot(input logic [SLOT_W-1:0] slot);
      fsa_rsp_type r;
      int          span;
      int          ch;
      logic [63:0] off;
      span = chunk_span();
      ch = int'(slot) / span;
      off = 64'(int'(slot) - ch * span) * padded_size();
      if (off > 64'(OFFSET_MAX)) off = 64'(OFFSET_MAX);
      r.slot_out    = slot;
      r.chunk       = ch[CHUNK_W-1:0];
      r.byte_offset = off[OFFSET_W-1:0];
      r.status      = ST_OK;
      return r;
   endfunction

   function automatic fsa_rsp_type allocator_outcome(input fsa_req_type r);
      fsa_rsp_type o;
      int          span;
      int          got;
      span = chunk_span();
      o = '0;
      o.slot_out = r.slot;
      case (r.cmd)
         CMD_ALLOC: begin
            if (int'(next_fresh) < span) begin
               got = (int'(open_chunks) - 1) * span + int'(next_fresh);
               next_fresh = next_fresh + 1'b1;
            end else if (free_count != '0) begin
               got = int'(freed_slots[free_head]);
               free_head = free_head + 1'b1;
               free_count = free_count - 1'b1;
            end else if (int'(open_chunks) < MAX_CHUNKS) begin
               got = int'(open_chunks) * span;
               open_chunks = open_chunks + 1'b1;
               next_fresh = SLOT_W'(1);
            end else begin
               got = -1;
            end
            if (got < 0) begin
               o.slot_out = '0;
               o.status   = ST_OUT_OF_SPACE;
            end else begin
               o = place_slot(got[SLOT_W-1:0]);
            end
         end
         CMD_FREE: begin
            if (free_count >= QCOUNT_W'(QDEPTH)) begin
               o.status = ST_QUEUE_FULL;
            end else begin
               freed_slots[free_tail] = r.slot;
               free_tail = free_tail + 1'b1;
               free_count = free_count + 1'b1;
            end
         end
         CMD_LOCATE: begin
            o = place_slot(r.slot);
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         object_size_q = OBJECT_SIZE_RESET;
         alignment_q   = ALIGNMENT_RESET;
         spc_q         = SLOTS_PER_CHUNK_RESET;
         open_chunks   = CHUNKS_W'(1);
         next_fresh    = '0;
         free_head     = '0;
         free_tail     = '0;
         free_count    = '0;
         pending_outcomes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_OBJECT_SIZE:     object_size_q = csr_pwdata[OBJ_SIZE_W-1:0];
               REG_ALIGNMENT:       alignment_q   = csr_pwdata[ALIGN_W-1:0];
               REG_SLOTS_PER_CHUNK: spc_q         = csr_pwdata[SPC_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected transaction: slot=%0d chunk=%0d offset=%0d status=%0d",
                           rsp_data.slot_out, rsp_data.chunk, rsp_data.byte_offset,
                           rsp_data.status);
            end else begin
               oldest = pending_outcomes.pop_front();
               if (rsp_data.slot_out !== oldest.slot_out || rsp_data.chunk !== oldest.chunk ||
                   rsp_data.byte_offset !== oldest.byte_offset ||
                   rsp_data.status !== oldest.status) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("mismatch: expected slot=%0d chunk=%0d offset=%0d status=%0d, %s",
                              oldest.slot_out, oldest.chunk, oldest.byte_offset, oldest.status,
                              $sformatf("got slot=%0d chunk=%0d offset=%0d status=%0d",
                                        rsp_data.slot_out, rsp_data.chunk,
                                        rsp_data.byte_offset, rsp_data.status));
               end
            end
         end
         if (req_valid && !req_stall)
            pending_outcomes.insert(pending_outcomes.size(), allocator_outcome(req_data));
      end
      fail_count      <= failures;
      pending_results <= pending_outcomes.size();
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Top of the slot allocator testbench: clock, reset, commands, register writes,
// result back-pressure, watchdog and verdict.
// Depends on fsa_pkg, fifo_slot_allocator_unit and slot_outcome_checker.
`default_nettype none

module testbench;
   import fsa_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 100;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   fsa_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   fsa_rsp_type           rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending_results;
   bit                    calm;
   int                    idle_cycles;

   fifo_slot_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   slot_outcome_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
      fsa_req_type r;
      int          gap;
      r.cmd  = cmd;
      r.slot = slot;
      gap = calm ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] obj, input logic [CSR_DATA_W-1:0] align,
                            input logic [CSR_DATA_W-1:0] spc);
      drain_results();
      write_reg(REG_OBJECT_SIZE, obj);
      write_reg(REG_ALIGNMENT, align);
      write_reg(REG_SLOTS_PER_CHUNK, spc);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         issue(CMD_ALLOC, SLOT_W'($urandom));
      else if (pick < 70)
         issue(CMD_FREE, ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom)
                                                      : SLOT_W'($urandom_range(0, 1023)));
      else if (pick < 95)
         issue(CMD_LOCATE, SLOT_W'($urandom));
      else
         issue(CMD_UNDEFINED, SLOT_W'($urandom));
   endtask

   task automatic random_phase(input logic [CSR_DATA_W-1:0] obj,
                               input logic [CSR_DATA_W-1:0] align,
                               input logic [CSR_DATA_W-1:0] spc);
      configure(obj, align, spc);
      calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) random_item();
   endtask

   initial begin : result_sink
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 10);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] align_pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      calm        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue(CMD_ALLOC, SLOT_W'(12'hFFF));
      issue(CMD_ALLOC, '0);
      issue(CMD_LOCATE, '0);
      issue(CMD_LOCATE, SLOT_W'(12'hFFF));
      issue(CMD_LOCATE, SLOT_W'(64));
      issue(CMD_LOCATE, SLOT_W'(63));
      issue(CMD_FREE, SLOT_W'(1));
      issue(CMD_FREE, SLOT_W'(1));
      issue(CMD_FREE, SLOT_W'(12'hFFF));
      issue(CMD_UNDEFINED, SLOT_W'(12'hFFF));
      issue(CMD_UNDEFINED, '0);
      issue(CMD_ALLOC, '0);
      issue(CMD_ALLOC, SLOT_W'(12'hAAA));
      issue(CMD_ALLOC, SLOT_W'(12'h555));
      // shrink the chunk below the fresh position: queue first, then a new chunk
      configure(256, 256, 3);
      repeat (4) issue(CMD_ALLOC, '0);
      issue(CMD_LOCATE, SLOT_W'(5));

      random_phase(65536, 4096, 256);
      random_phase(100, 24, 0);
      random_phase(3, 1, 7);
      repeat (3) begin
         case ($urandom_range(0, 2))
            0:       align_pick = 0;
            1:       align_pick = 1 << $urandom_range(0, 12);
            default: align_pick = $urandom_range(0, 4096);
         endcase
         random_phase($urandom_range(1, 65536), align_pick, $urandom_range(1, 256));
      end
      random_phase(32'h1FFFF, 32'h1FFF, 32'h1FF);
      random_phase(1, 0, 1);

      // exhaust the queue and every chunk
      calm = 1'b0;
      repeat (300) issue(CMD_ALLOC, SLOT_W'($urandom));
      repeat (20) issue(CMD_ALLOC, SLOT_W'($urandom));
      repeat (10) issue(CMD_FREE, SLOT_W'($urandom));
      repeat (10) issue(CMD_LOCATE, SLOT_W'($urandom));

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/fsa_pkg.sv
rtl/fsa_ram.sv
rtl/fsa_div.sv
rtl/fifo_slot_allocator_unit.sv
tb/slot_outcome_checker.sv
tb/testbench.sv
